@@ hdl/ipdk_pkg.sv @@
// ============================================================================
// ipdk_pkg
// Shared types, constants and register map of the IR key toggler.
// ============================================================================
`default_nettype none

package ipdk_pkg;

    localparam int WORD_W         = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int FRAME_BITS_DEF = 16;
    localparam int MATCH_W        = 2;
    localparam int SW_W           = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 3'd7;

    // register reset values
    localparam logic [WORD_W-1:0] RST_START_MIN  = 16'd13000;
    localparam logic [WORD_W-1:0] RST_START_MAX  = 16'd14000;
    localparam logic [WORD_W-1:0] RST_ZERO_MIN   = 16'd2000;
    localparam logic [WORD_W-1:0] RST_ZERO_MAX   = 16'd3000;
    localparam logic [WORD_W-1:0] RST_ONE_MIN    = 16'd4200;
    localparam logic [WORD_W-1:0] RST_ONE_MAX    = 16'd5800;
    localparam logic [WORD_W-1:0] RST_KEY_FIRST  = 16'h0817;
    localparam logic [WORD_W-1:0] RST_KEY_SECOND = 16'h0000;

    // event kinds
    localparam logic ACT_IR_EDGE = 1'b0;
    localparam logic ACT_SWITCH  = 1'b1;

    // key match codes
    localparam logic [MATCH_W-1:0] MATCH_NONE   = 2'd0;
    localparam logic [MATCH_W-1:0] MATCH_FIRST  = 2'd1;
    localparam logic [MATCH_W-1:0] MATCH_SECOND = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] start_min;
        logic [WORD_W-1:0] start_max;
        logic [WORD_W-1:0] zero_min;
        logic [WORD_W-1:0] zero_max;
        logic [WORD_W-1:0] one_min;
        logic [WORD_W-1:0] one_max;
        logic [WORD_W-1:0] key_first_light;
        logic [WORD_W-1:0] key_second_light;
    } t_cfg;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] interval;
        logic [SW_W-1:0]   switches_pressed;
    } t_item;

    typedef struct packed {
        logic               light_first;
        logic               light_second;
        logic               frame_done;
        logic [WORD_W-1:0]  received_code;
        logic [MATCH_W-1:0] key_match;
    } t_result;

    // strict window test: lo < v < hi
    function automatic logic in_window(input logic [WORD_W-1:0] v,
                                       input logic [WORD_W-1:0] lo,
                                       input logic [WORD_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

endpackage

`default_nettype wire

@@ hdl/ipdk_if.sv @@
// ============================================================================
// ipdk_if
// Valid/ready channels for IR events and toggler results.
// ============================================================================
`default_nettype none

interface ipdk_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [ipdk_pkg::WORD_W-1:0]     interval;
    logic [ipdk_pkg::SW_W-1:0]       switches_pressed;

    modport source (output valid, action, interval, switches_pressed, input ready);
    modport sink   (input valid, action, interval, switches_pressed, output ready);
endinterface

interface ipdk_out_if;
    logic                            valid;
    logic                            ready;
    logic                            light_first;
    logic                            light_second;
    logic                            frame_done;
    logic [ipdk_pkg::WORD_W-1:0]     received_code;
    logic [ipdk_pkg::MATCH_W-1:0]    key_match;

    modport source (output valid, light_first, light_second, frame_done,
                    received_code, key_match, input ready);
    modport sink   (input valid, light_first, light_second, frame_done,
                    received_code, key_match, output ready);
endinterface

`default_nettype wire

@@ hdl/ir_pulse_distance_key_toggler_core.sv @@
// ============================================================================
// ir_pulse_distance_key_toggler_core
// Pulse-distance IR frame decoder that toggles two lights.
// ============================================================================
// Usage:
//   i_evt  - event channel. action 0 is a falling IR edge with the interval in
//            microseconds since the previous edge; action 1 is a switch event
//            whose switches_pressed bits toggle the lights.
//   o_res  - one result transaction per event: both light states after the
//            event, frame_done/received_code/key_match for a finished frame
//            (code and match read zero otherwise).
//   i_cfg_* - write-only register port (windows and key codes); the user must
//            write it only while no event is in flight; the block does not check.
// Timing:
//   An event goes into an input register, is decoded by the window compares
//   and shift logic and lands in the result register, which drives
//   o_res.valid. One event per cycle sustained while o_res.ready stays high.
// Reset:
//   Synchronous, active low. Registers take their default windows, the frame
//   state clears and both lights go off. Both channels come up empty.
// Back-pressure:
//   While a result waits on o_res.ready, one more event can be taken into the
//   input register; after that i_evt.ready stays low until the result leaves.
// ============================================================================
`default_nettype none

module ir_pulse_distance_key_toggler_core #(
    parameter int FRAME_BITS = ipdk_pkg::FRAME_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    ipdk_in_if.sink                                i_evt,
    ipdk_out_if.source                             o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [ipdk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ipdk_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    ipdk_pkg::t_cfg    cfg;
    ipdk_pkg::t_item   r_item;
    ipdk_pkg::t_result res_next;
    ipdk_pkg::t_result r_res;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              adv;

    // decode stage moves when the result register is free or draining
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || adv;

    ipdk_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    ipdk_decode #(
        .FRAME_BITS (FRAME_BITS)
    ) u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res_next)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_item.action           <= i_evt.action;
            r_item.interval         <= i_evt.interval;
            r_item.switches_pressed <= i_evt.switches_pressed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res_next;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.light_first   = r_res.light_first;
    assign o_res.light_second  = r_res.light_second;
    assign o_res.frame_done    = r_res.frame_done;
    assign o_res.received_code = r_res.received_code;
    assign o_res.key_match     = r_res.key_match;

endmodule

`default_nettype wire

@@ hdl/ipdk_cfg_regs.sv @@
// ============================================================================
// ipdk_cfg_regs
// Window and key code registers, write-only.
// ============================================================================
`default_nettype none

module ipdk_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_we,
    input  wire logic [ipdk_pkg::CFG_IDX_W-1:0]    i_idx,
    input  wire logic [ipdk_pkg::CFG_DATA_W-1:0]   i_wdata,
    output ipdk_pkg::t_cfg                         o_cfg
);

    ipdk_pkg::t_cfg r_cfg;
    ipdk_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                ipdk_pkg::REG_START_MIN:  n_cfg.start_min        = i_wdata;
                ipdk_pkg::REG_START_MAX:  n_cfg.start_max        = i_wdata;
                ipdk_pkg::REG_ZERO_MIN:   n_cfg.zero_min         = i_wdata;
                ipdk_pkg::REG_ZERO_MAX:   n_cfg.zero_max         = i_wdata;
                ipdk_pkg::REG_ONE_MIN:    n_cfg.one_min          = i_wdata;
                ipdk_pkg::REG_ONE_MAX:    n_cfg.one_max          = i_wdata;
                ipdk_pkg::REG_KEY_FIRST:  n_cfg.key_first_light  = i_wdata;
                ipdk_pkg::REG_KEY_SECOND: n_cfg.key_second_light = i_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_min        <= ipdk_pkg::RST_START_MIN;
            r_cfg.start_max        <= ipdk_pkg::RST_START_MAX;
            r_cfg.zero_min         <= ipdk_pkg::RST_ZERO_MIN;
            r_cfg.zero_max         <= ipdk_pkg::RST_ZERO_MAX;
            r_cfg.one_min          <= ipdk_pkg::RST_ONE_MIN;
            r_cfg.one_max          <= ipdk_pkg::RST_ONE_MAX;
            r_cfg.key_first_light  <= ipdk_pkg::RST_KEY_FIRST;
            r_cfg.key_second_light <= ipdk_pkg::RST_KEY_SECOND;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/ipdk_decode.sv @@
// ============================================================================
// ipdk_decode
// Frame decoder state and light toggles; one event per advance.
// ============================================================================
`default_nettype none

module ipdk_decode #(
    parameter int FRAME_BITS = ipdk_pkg::FRAME_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire ipdk_pkg::t_item  i_item,
    input  wire ipdk_pkg::t_cfg   i_cfg,
    output ipdk_pkg::t_result     o_res
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BITS - 1);

    logic                            r_in_frame, n_in_frame;
    logic [CNT_W-1:0]                r_bit_cnt, n_bit_cnt;
    logic [ipdk_pkg::WORD_W-1:0]     r_word, n_word;
    logic                            r_light1, n_light1;
    logic                            r_light2, n_light2;

    logic                            is_one;
    logic                            is_zero;
    logic                            is_start;
    logic [ipdk_pkg::WORD_W-1:0]     shifted;

    assign is_start = ipdk_pkg::in_window(i_item.interval, i_cfg.start_min, i_cfg.start_max);
    assign is_one   = ipdk_pkg::in_window(i_item.interval, i_cfg.one_min, i_cfg.one_max);
    assign is_zero  = ipdk_pkg::in_window(i_item.interval, i_cfg.zero_min, i_cfg.zero_max);
    assign shifted  = {is_one, r_word[ipdk_pkg::WORD_W-1:1]};

    always_comb begin
        n_in_frame = r_in_frame;
        n_bit_cnt  = r_bit_cnt;
        n_word     = r_word;
        n_light1   = r_light1;
        n_light2   = r_light2;
        o_res.frame_done    = 1'b0;
        o_res.received_code = '0;
        o_res.key_match     = ipdk_pkg::MATCH_NONE;

        if (i_item.action == ipdk_pkg::ACT_SWITCH) begin
            n_light1 = r_light1 ^ i_item.switches_pressed[0];
            n_light2 = r_light2 ^ i_item.switches_pressed[1];
        end else if (!r_in_frame) begin
            // idle: open a frame or stay cleared
            n_in_frame = is_start;
            n_bit_cnt  = '0;
            n_word     = '0;
        end else if (is_one || is_zero) begin
            if (r_bit_cnt == LAST_CNT) begin
                o_res.frame_done    = 1'b1;
                o_res.received_code = shifted;
                if (shifted == i_cfg.key_first_light) begin
                    o_res.key_match = ipdk_pkg::MATCH_FIRST;
                    n_light1        = ~r_light1;
                end else if (shifted == i_cfg.key_second_light) begin
                    o_res.key_match = ipdk_pkg::MATCH_SECOND;
                    n_light2        = ~r_light2;
                end
                n_in_frame = 1'b0;
                n_bit_cnt  = '0;
                n_word     = '0;
            end else begin
                n_bit_cnt = r_bit_cnt + 1'b1;
                n_word    = shifted;
            end
        end

        o_res.light_first  = n_light1;
        o_res.light_second = n_light2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_bit_cnt  <= '0;
            r_word     <= '0;
            r_light1   <= 1'b0;
            r_light2   <= 1'b0;
        end else if (i_adv) begin
            r_in_frame <= n_in_frame;
            r_bit_cnt  <= n_bit_cnt;
            r_word     <= n_word;
            r_light1   <= n_light1;
            r_light2   <= n_light2;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ipdk_checker.sv @@
// ============================================================================
// ipdk_checker
// Port-level checks on the result channel of the key toggler.
// ============================================================================
`default_nettype none

module ipdk_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic                             i_ready,
    input  wire logic                             i_frame_done,
    input  wire logic [ipdk_pkg::WORD_W-1:0]      i_code,
    input  wire logic [ipdk_pkg::MATCH_W-1:0]     i_match
);

    // a key match only comes with a finished frame
    a_match_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_match != ipdk_pkg::MATCH_NONE) |-> i_frame_done)
        else $error("key match without frame end");

    // no frame: code and match read zero
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_frame_done |-> (i_code == '0) && (i_match == ipdk_pkg::MATCH_NONE))
        else $error("code or match set without frame end");

    // only the defined match codes appear
    a_match_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_match == ipdk_pkg::MATCH_NONE) || (i_match == ipdk_pkg::MATCH_FIRST)
                    || (i_match == ipdk_pkg::MATCH_SECOND))
        else $error("undefined key match code");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code) && $stable(i_frame_done))
        else $error("result changed while stalled");

endmodule

bind ir_pulse_distance_key_toggler_core ipdk_checker u_ipdk_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_frame_done (o_res.frame_done),
    .i_code       (o_res.received_code),
    .i_match      (o_res.key_match)
);

`default_nettype wire
